/* rtl/core/wps_pkg.sv */
// Shared types and constants for the widest path search unit.
`default_nettype none
package wps_pkg;

    localparam int NODE_W      = 10;
    localparam int WEIGHT_W    = 30;
    localparam int MAX_NODES   = 1024;
    localparam int MAX_EDGES   = 4096;
    localparam int EDGE_AW     = $clog2(MAX_EDGES);
    localparam int EDGE_CNT_W  = EDGE_AW + 1;
    localparam int NODE_AW     = $clog2(MAX_NODES);

    localparam logic [WEIGHT_W-1:0] TOP_THRESHOLD = WEIGHT_W'(1000000000);

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_NODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FINISH_NODE = 2'd2;

    // One stored edge
    typedef struct packed {
        logic [NODE_W-1:0]   end_a;
        logic [NODE_W-1:0]   end_b;
        logic [WEIGHT_W-1:0] weight;
    } edge_t;

    // Sequencer states
    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_CLR  = 10'b00_0000_0010,
        ST_SEED = 10'b00_0000_0100,
        ST_ERD  = 10'b00_0000_1000,
        ST_VRD  = 10'b00_0001_0000,
        ST_UPD  = 10'b00_0010_0000,
        ST_FRD  = 10'b00_0100_0000,
        ST_EVAL = 10'b00_1000_0000,
        ST_MID  = 10'b01_0000_0000,
        ST_DONE = 10'b10_0000_0000
    } state_t;

endpackage
`default_nettype wire

/* rtl/core/widest_path_search_unit.sv */
// Top level: edge loading, threshold binary search and reachability sweeps.
// Edges load one transfer per cycle when idle; the last_edge item starts a search.
// Each probe clears the visited map one entry at a time, then sweeps the edge
// store edge by edge, repeating sweeps until no node is added; about 31 probes.
// Input is not ready during the search; the result register frees the search.
// Synchronous active-low reset returns to idle with an empty store and reset
// register values; the visited map is cleared at the start of every probe.
`default_nettype none
module widest_path_search_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [wps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [wps_pkg::NODE_W-1:0]    cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [wps_pkg::NODE_W-1:0]    s_end_a,
    input  wire logic [wps_pkg::NODE_W-1:0]    s_end_b,
    input  wire logic [wps_pkg::WEIGHT_W-1:0]  s_edge_weight,
    input  wire logic                          s_last_edge,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_found,
    output logic [wps_pkg::WEIGHT_W-1:0]       m_widest
);

    localparam int NW = wps_pkg::NODE_W;
    localparam int WW = wps_pkg::WEIGHT_W;
    localparam int AW = wps_pkg::EDGE_AW;
    localparam int CW = wps_pkg::EDGE_CNT_W;
    localparam int VW = wps_pkg::NODE_AW;

    wps_pkg::state_t state_reg, state_next;

    logic [NW-1:0] node_count_reg, start_node_reg, finish_node_reg;
    logic [CW-1:0] edge_total_reg, edge_total_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [VW-1:0] clr_reg, clr_next;
    logic          changed_reg, changed_next;
    logic          first_reg, first_next;
    logic [WW-1:0] thr_reg, thr_next;
    logic [WW-1:0] low_reg, low_next;
    logic [WW-1:0] high_reg, high_next;
    logic [WW-1:0] best_reg, best_next;
    logic          res_found_reg, res_found_next;
    logic [WW-1:0] res_widest_reg, res_widest_next;
    logic          m_valid_reg, m_valid_next;
    logic          m_found_reg, m_found_next;
    logic [WW-1:0] m_widest_reg, m_widest_next;

    // Visited map memory
    logic          vis_mem [wps_pkg::MAX_NODES];
    logic          vis_we;
    logic [VW-1:0] vis_waddr;
    logic          vis_wdata;
    logic          vis_re;
    logic [VW-1:0] vis_raddr_a, vis_raddr_b;
    logic          vis_qa_reg, vis_qb_reg;

    // Edge store
    logic           in_xfer;
    logic           edge_we;
    wps_pkg::edge_t edge_wdata, edge_q;
    logic           edge_re;

    logic edge_ok, start_ok, finish_ok, a_ok, b_ok, last_idx;

    assign in_xfer = s_valid && s_ready;
    assign s_ready = (state_reg == wps_pkg::ST_IDLE);
    assign edge_we = in_xfer && (edge_total_reg < CW'(wps_pkg::MAX_EDGES));
    assign edge_wdata = '{end_a: s_end_a, end_b: s_end_b, weight: s_edge_weight};
    assign edge_re = (state_reg == wps_pkg::ST_ERD);

    wps_edge_store u_edges (
        .aclk    (aclk),
        .wr_en   (edge_we),
        .wr_addr (edge_total_reg[AW-1:0]),
        .wr_data (edge_wdata),
        .rd_en   (edge_re),
        .rd_addr (idx_reg),
        .rd_data (edge_q)
    );

    // Node range checks
    assign start_ok  = (start_node_reg != '0) && (start_node_reg <= node_count_reg);
    assign finish_ok = (finish_node_reg != '0) && (finish_node_reg <= node_count_reg);
    assign a_ok      = (edge_q.end_a != '0) && (edge_q.end_a <= node_count_reg);
    assign b_ok      = (edge_q.end_b != '0) && (edge_q.end_b <= node_count_reg);
    assign edge_ok   = a_ok && b_ok && (edge_q.weight >= thr_reg);
    assign last_idx  = ({1'b0, idx_reg} + CW'(1)) >= edge_total_reg;

    // Visited map memory ports
    always_ff @(posedge aclk) begin
        if (vis_we) begin
            vis_mem[vis_waddr] <= vis_wdata;
        end
        if (vis_re) begin
            vis_qa_reg <= vis_mem[vis_raddr_a];
            vis_qb_reg <= vis_mem[vis_raddr_b];
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg  <= NW'(1);
            start_node_reg  <= NW'(1);
            finish_node_reg <= NW'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                wps_pkg::CFG_NODE_COUNT:  node_count_reg  <= cfg_wdata;
                wps_pkg::CFG_START_NODE:  start_node_reg  <= cfg_wdata;
                wps_pkg::CFG_FINISH_NODE: finish_node_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        edge_total_next = edge_total_reg;
        idx_next        = idx_reg;
        clr_next        = clr_reg;
        changed_next    = changed_reg;
        first_next      = first_reg;
        thr_next        = thr_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        best_next       = best_reg;
        res_found_next  = res_found_reg;
        res_widest_next = res_widest_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_found_next    = m_found_reg;
        m_widest_next   = m_widest_reg;
        vis_we          = 1'b0;
        vis_waddr       = clr_reg;
        vis_wdata       = 1'b0;
        vis_re          = 1'b0;
        vis_raddr_a     = edge_q.end_a;
        vis_raddr_b     = edge_q.end_b;

        unique case (state_reg)
            wps_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    if (edge_we) begin
                        edge_total_next = edge_total_reg + CW'(1);
                    end
                    if (s_last_edge) begin
                        first_next = 1'b1;
                        thr_next   = '0;
                        best_next  = '0;
                        clr_next   = '0;
                        state_next = wps_pkg::ST_CLR;
                    end
                end
            end
            // Clear the visited map, one entry a cycle
            wps_pkg::ST_CLR: begin
                vis_we    = 1'b1;
                vis_waddr = clr_reg;
                clr_next  = clr_reg + VW'(1);
                if (clr_reg == VW'(wps_pkg::MAX_NODES - 1)) begin
                    state_next = wps_pkg::ST_SEED;
                end
            end
            wps_pkg::ST_SEED: begin
                vis_we       = 1'b1;
                vis_waddr    = start_node_reg;
                vis_wdata    = 1'b1;
                idx_next     = '0;
                changed_next = 1'b0;
                state_next   = wps_pkg::ST_ERD;
            end
            wps_pkg::ST_ERD: begin
                state_next = wps_pkg::ST_VRD;
            end
            wps_pkg::ST_VRD: begin
                vis_re     = 1'b1;
                state_next = wps_pkg::ST_UPD;
            end
            // Mark the far end when the edge passes the threshold and exactly one end is reached
            wps_pkg::ST_UPD: begin
                if (edge_ok && (vis_qa_reg != vis_qb_reg)) begin
                    vis_we       = 1'b1;
                    vis_waddr    = vis_qa_reg ? edge_q.end_b : edge_q.end_a;
                    vis_wdata    = 1'b1;
                    changed_next = 1'b1;
                end
                if (last_idx) begin
                    idx_next = '0;
                    if (changed_next) begin
                        changed_next = 1'b0;
                        state_next   = wps_pkg::ST_ERD;
                    end else begin
                        state_next = wps_pkg::ST_FRD;
                    end
                end else begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = wps_pkg::ST_ERD;
                end
            end
            wps_pkg::ST_FRD: begin
                vis_re      = 1'b1;
                vis_raddr_a = finish_node_reg;
                state_next  = wps_pkg::ST_EVAL;
            end
            // Probe outcome
            wps_pkg::ST_EVAL: begin
                if (first_reg) begin
                    first_next = 1'b0;
                    if (start_ok && finish_ok && vis_qa_reg) begin
                        low_next   = WW'(1);
                        high_next  = wps_pkg::TOP_THRESHOLD;
                        state_next = wps_pkg::ST_MID;
                    end else begin
                        res_found_next  = 1'b0;
                        res_widest_next = '0;
                        state_next      = wps_pkg::ST_DONE;
                    end
                end else begin
                    if (start_ok && finish_ok && vis_qa_reg) begin
                        best_next = thr_reg;
                        low_next  = thr_reg + WW'(1);
                    end else begin
                        high_next = thr_reg - WW'(1);
                    end
                    state_next = wps_pkg::ST_MID;
                end
            end
            wps_pkg::ST_MID: begin
                if (low_reg <= high_reg) begin
                    thr_next   = low_reg + ((high_reg - low_reg) >> 1);
                    clr_next   = '0;
                    state_next = wps_pkg::ST_CLR;
                end else begin
                    res_found_next  = 1'b1;
                    res_widest_next = best_reg;
                    state_next      = wps_pkg::ST_DONE;
                end
            end
            // Hand the result to the output register once it is free
            wps_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_found_next    = res_found_reg;
                    m_widest_next   = res_widest_reg;
                    edge_total_next = '0;
                    state_next      = wps_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wps_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= wps_pkg::ST_IDLE;
            edge_total_reg <= '0;
            m_valid_reg    <= 1'b0;
            first_reg      <= 1'b0;
            changed_reg    <= 1'b0;
            best_reg       <= '0;
            low_reg        <= WW'(1);
            high_reg       <= wps_pkg::TOP_THRESHOLD;
        end else begin
            state_reg      <= state_next;
            edge_total_reg <= edge_total_next;
            m_valid_reg    <= m_valid_next;
            first_reg      <= first_next;
            changed_reg    <= changed_next;
            best_reg       <= best_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        clr_reg        <= clr_next;
        thr_reg        <= thr_next;
        res_found_reg  <= res_found_next;
        res_widest_reg <= res_widest_next;
        m_found_reg    <= m_found_next;
        m_widest_reg   <= m_widest_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_found  = m_found_reg;
    assign m_widest = m_widest_reg;

`ifndef SYNTH
    // A not-found result always carries a zero width
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_found_reg) |-> (m_widest_reg == '0))
        else $error("not-found result with nonzero width");

    // Best threshold never exceeds the search ceiling
    assert property (@(posedge aclk) disable iff (!aresetn)
        best_reg <= wps_pkg::TOP_THRESHOLD)
        else $error("best threshold above ceiling");

    // Sweep index stays inside the loaded edges
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wps_pkg::ST_ERD) |-> ({1'b0, idx_reg} < edge_total_reg))
        else $error("sweep index beyond edge count");

    // A finished search leaves the store empty for the next graph
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wps_pkg::ST_DONE && state_next == wps_pkg::ST_IDLE)
        |=> (edge_total_reg == '0 && m_valid_reg))
        else $error("result handoff did not reset edge count");
`endif

endmodule
`default_nettype wire

/* rtl/core/wps_edge_store.sv */
// Edge store: single-port write, registered read synchronous RAM.
`default_nettype none
module wps_edge_store (
    input  wire logic                        aclk,
    input  wire logic                        wr_en,
    input  wire logic [wps_pkg::EDGE_AW-1:0] wr_addr,
    input  wire wps_pkg::edge_t              wr_data,
    input  wire logic                        rd_en,
    input  wire logic [wps_pkg::EDGE_AW-1:0] rd_addr,
    output wps_pkg::edge_t                   rd_data
);

    wps_pkg::edge_t mem [wps_pkg::MAX_EDGES];
    wps_pkg::edge_t rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

/* tb/widest_path_search_unit_test.sv */
// Self-checking testbench for the widest path search unit: edge streams with predicted results.
module widest_path_search_unit_test;

    localparam int  CYCLE_LIMIT = 60_000_000;
    localparam int  ERR_SHOW    = 10;

    typedef struct {
        logic [wps_pkg::NODE_W-1:0]   end_a;
        logic [wps_pkg::NODE_W-1:0]   end_b;
        logic [wps_pkg::WEIGHT_W-1:0] weight;
        logic                         last;
    } edge_item_t;

    typedef struct {
        logic                         found;
        logic [wps_pkg::WEIGHT_W-1:0] widest;
    } path_result_t;

    logic                             aclk          = 1'b0;
    logic                             aresetn       = 1'b0;
    logic                             cfg_we        = 1'b0;
    logic [wps_pkg::CFG_IDX_W-1:0]    cfg_index     = wps_pkg::CFG_NODE_COUNT;
    logic [wps_pkg::NODE_W-1:0]       cfg_wdata     = '0;
    logic                             s_valid       = 1'b0;
    logic                             s_ready;
    logic [wps_pkg::NODE_W-1:0]       s_end_a       = '0;
    logic [wps_pkg::NODE_W-1:0]       s_end_b       = '0;
    logic [wps_pkg::WEIGHT_W-1:0]     s_edge_weight = '0;
    logic                             s_last_edge   = 1'b0;
    logic                             m_valid;
    logic                             m_ready       = 1'b0;
    logic                             m_found;
    logic [wps_pkg::WEIGHT_W-1:0]     m_widest;

    widest_path_search_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_end_a(s_end_a), .s_end_b(s_end_b),
        .s_edge_weight(s_edge_weight), .s_last_edge(s_last_edge),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_found(m_found), .m_widest(m_widest)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Shadow of the block state
    logic [wps_pkg::NODE_W-1:0]   shadow_nodes  = 10'd1;
    logic [wps_pkg::NODE_W-1:0]   shadow_start  = 10'd1;
    logic [wps_pkg::NODE_W-1:0]   shadow_finish = 10'd1;
    logic [wps_pkg::NODE_W-1:0]   graph_a [wps_pkg::MAX_EDGES];
    logic [wps_pkg::NODE_W-1:0]   graph_b [wps_pkg::MAX_EDGES];
    logic [wps_pkg::WEIGHT_W-1:0] graph_w [wps_pkg::MAX_EDGES];
    int                           graph_edges = 0;

    edge_item_t   edge_queue[$];
    path_result_t result_queue[$];
    edge_item_t   on_bus;
    int           send_gap  = 0;
    int           sink_gap  = 0;
    bit           quiet     = 0;
    int           fail_count = 0;
    int           cycles    = 0;

    // Bottleneck of the best start-to-finish path by max-min relaxation
    function automatic path_result_t widest_path();
        path_result_t r;
        longint       best [wps_pkg::MAX_NODES];
        int           lim;
        bit           changed;
        longint       cand;
        int           u, v;
        lim = int'(shadow_nodes);
        r.found  = 1'b0;
        r.widest = '0;
        if (shadow_start < 1 || shadow_start > lim || shadow_finish < 1 || shadow_finish > lim)
            return r;
        foreach (best[i]) best[i] = -1;
        best[shadow_start] = 64'd1 << 31;
        do begin
            changed = 0;
            for (int i = 0; i < graph_edges; i++) begin
                if (graph_a[i] < 1 || graph_a[i] > lim || graph_b[i] < 1 || graph_b[i] > lim)
                    continue;
                for (int d = 0; d < 2; d++) begin
                    u = d ? graph_b[i] : graph_a[i];
                    v = d ? graph_a[i] : graph_b[i];
                    if (best[u] < 0) continue;
                    cand = (best[u] < graph_w[i]) ? best[u] : graph_w[i];
                    if (cand > best[v]) begin
                        best[v] = cand;
                        changed = 1;
                    end
                end
            end
        end while (changed);
        if (best[shadow_finish] >= 0) begin
            r.found  = 1'b1;
            r.widest = (best[shadow_finish] > wps_pkg::TOP_THRESHOLD)
                     ? wps_pkg::TOP_THRESHOLD
                     : wps_pkg::WEIGHT_W'(best[shadow_finish]);
        end
        return r;
    endfunction

    // Store an accepted edge; the closing edge yields one result
    function automatic void take_edge(edge_item_t it);
        if (graph_edges < wps_pkg::MAX_EDGES) begin
            graph_a[graph_edges] = it.end_a;
            graph_b[graph_edges] = it.end_b;
            graph_w[graph_edges] = it.weight;
            graph_edges++;
        end
        if (it.last) begin
            result_queue = {result_queue, widest_path()};
            graph_edges = 0;
        end
    endfunction

    // Input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) take_edge(on_bus);
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (edge_queue.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 8);
                    s_valid <= 1'b0;
                end else begin
                    on_bus = edge_queue.pop_front();
                    s_valid       <= 1'b1;
                    s_end_a       <= on_bus.end_a;
                    s_end_b       <= on_bus.end_b;
                    s_edge_weight <= on_bus.weight;
                    s_last_edge   <= on_bus.last;
                end
            end
        end
    end

    // Result monitor with receiver stalls
    always @(posedge aclk) begin
        path_result_t want;
        if (!aresetn) begin
            m_ready  <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (result_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= ERR_SHOW)
                        $display("unexpected result: found=%0d widest=%0d", m_found, m_widest);
                end else begin
                    want = result_queue.pop_front();
                    if (m_found !== want.found || m_widest !== want.widest) begin
                        fail_count++;
                        if (fail_count <= ERR_SHOW)
                            $display({"mismatch: expected found=%0d widest=%0d,",
                                      " got found=%0d widest=%0d"},
                                     want.found, want.widest, m_found, m_widest);
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                sink_gap = $urandom_range(0, 8);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic wait_idle();
        while (edge_queue.size() != 0 || result_queue.size() != 0 || s_valid)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write all three registers, back to back
    task automatic set_graph_regs(int nodes, int start, int finish);
        wait_idle();
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= wps_pkg::CFG_NODE_COUNT;
        cfg_wdata <= wps_pkg::NODE_W'(nodes);
        @(posedge aclk);
        cfg_index <= wps_pkg::CFG_START_NODE; cfg_wdata <= wps_pkg::NODE_W'(start);
        @(posedge aclk);
        cfg_index <= wps_pkg::CFG_FINISH_NODE; cfg_wdata <= wps_pkg::NODE_W'(finish);
        @(posedge aclk);
        cfg_we <= 1'b0;
        shadow_nodes  = wps_pkg::NODE_W'(nodes);
        shadow_start  = wps_pkg::NODE_W'(start);
        shadow_finish = wps_pkg::NODE_W'(finish);
    endtask

    function automatic void add_edge(int a, int b, logic [wps_pkg::WEIGHT_W-1:0] w, bit last);
        edge_item_t it;
        it.end_a  = wps_pkg::NODE_W'(a);
        it.end_b  = wps_pkg::NODE_W'(b);
        it.weight = w;
        it.last   = last;
        edge_queue = {edge_queue, it};
    endfunction

    function automatic logic [wps_pkg::WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return wps_pkg::TOP_THRESHOLD;
            2:       return wps_pkg::WEIGHT_W'($urandom);
            3:       return wps_pkg::WEIGHT_W'($urandom_range(1, 40));
            4:       return wps_pkg::WEIGHT_W'($urandom_range(999_999_990, 1_000_000_010));
            default: return wps_pkg::WEIGHT_W'($urandom_range(0, 1_000_000_000));
        endcase
    endfunction

    function automatic int pick_node(int nodes);
        if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1023);
        return $urandom_range(1, (nodes < 1) ? 1 : nodes);
    endfunction

    // One random graph with its own register setting
    task automatic random_graph(inout int sent);
        int nodes, count, start, finish;
        case ($urandom_range(0, 19))
            0:       nodes = 0;
            1:       nodes = 1023;
            2:       nodes = 1;
            default: nodes = $urandom_range(2, 10);
        endcase
        count  = (nodes == 1023) ? $urandom_range(1, 8) : $urandom_range(1, 30);
        start  = pick_node(nodes);
        finish = ($urandom_range(0, 9) == 0) ? start : pick_node(nodes);
        set_graph_regs(nodes, start, finish);
        for (int i = 0; i < count; i++)
            add_edge(pick_node(nodes), pick_node(nodes), pick_weight(), i == count - 1);
        sent += count;
    endtask

    initial begin
        int sent;
        sent = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Start equals finish: full width even over a zero-weight edge
        set_graph_regs(3, 2, 2);
        add_edge(1, 2, '0, 1);
        // Only zero-weight paths: found with zero width
        set_graph_regs(3, 1, 3);
        add_edge(1, 2, '0, 0);
        add_edge(2, 3, '0, 1);
        // Weight beyond the top threshold saturates
        set_graph_regs(2, 1, 2);
        add_edge(1, 2, {wps_pkg::WEIGHT_W{1'b1}}, 1);
        // Endpoints of zero and beyond the node limit are ignored
        set_graph_regs(4, 1, 4);
        add_edge(0, 4, 30'd9, 0);
        add_edge(1, 1023, 30'd9, 0);
        add_edge(1, 3, 30'd7, 0);
        add_edge(3, 4, 30'd2, 1);
        // Start out of range, then a node count of zero
        set_graph_regs(5, 6, 1);
        add_edge(1, 5, 30'd3, 1);
        set_graph_regs(0, 1, 1);
        add_edge(1, 1, 30'd3, 1);
        // Largest node count, parallel edges, unreachable finish
        set_graph_regs(1023, 1023, 1);
        add_edge(1023, 500, 30'd5, 0);
        add_edge(500, 1, 30'd1000, 0);
        add_edge(1, 1023, 30'd6, 0);
        add_edge(1, 1023, 30'd4, 1);
        set_graph_regs(1023, 1, 700);
        add_edge(1, 2, 30'd5, 0);
        add_edge(0, 0, '0, 1);

        while (sent < 1100) random_graph(sent);

        wait_idle();
        quiet = 1;
        while (sent < 1350) random_graph(sent);

        wait_idle();
        repeat (50) @(posedge aclk);
        if (fail_count == 0 && result_queue.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* widest_path_search_unit.f */
rtl/core/wps_pkg.sv
rtl/core/wps_edge_store.sv
rtl/core/widest_path_search_unit.sv
tb/widest_path_search_unit_test.sv
